// File: sv/mvd_pkg.sv
// Shared types and constants for the mesh vertex dedup and fan indexer.
// No dependencies.
package mvd_pkg;
  localparam int TableDepth = 4096;
  localparam int IndexBits  = 20;
  localparam int SlotBits   = $clog2(TableDepth);
  localparam int NumBits    = 12;
  localparam int CountBits  = SlotBits + 1;
  localparam int KeyBits    = 3 * IndexBits + 2;
  localparam int ProbeBits  = SlotBits + 1;
  localparam logic [63:0] HashMul = 64'h9E3779B97F4A7C15;

  typedef logic [KeyBits-1:0]  key_t;
  typedef logic [SlotBits-1:0] slot_t;
  typedef logic [NumBits-1:0]  num_t;

  typedef struct packed {
    logic load;
    logic hash_lo;
    logic hash_hi;
    logic hash_fin;
    logic read;
    logic advance;
    logic insert;
    logic finish;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic empty;
    logic exhausted;
    logic clear_done;
    logic no_number;
  } status_t;
endpackage

// File: sv/mesh_vertex_dedup_fan_indexer_top.sv
// Top level of the mesh vertex dedup and fan indexer.
// Depends on mvd_pkg, mvd_ctrl and mvd_datapath.
//
// Channel  | Handshake          | Payload
// input    | start, busy        | face_start, pos_index, uv_index, normal_index
// result   | valid (one cycle)  | vertex_number, is_new, tri_valid, tri_first,
//          |                    | tri_prev, tri_curr, table_full
//
// An item runs S_HASH1, S_HASH2, S_HASH3, then S_READ and S_CHECK per probe step of
// the linear search; the hash multiply is split over S_HASH1 and S_HASH2, and the table
// read is registered. After reset busy stays high while the valid bits are swept.
// The result is registered in the cycle after the decision and cannot be stalled.
module mesh_vertex_dedup_fan_indexer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               face_start,
  input  logic [19:0]        pos_index,
  input  logic signed [20:0] uv_index,
  input  logic signed [20:0] normal_index,
  output logic               valid,
  output logic [11:0]        vertex_number,
  output logic               is_new,
  output logic               tri_valid,
  output logic [11:0]        tri_first,
  output logic [11:0]        tri_prev,
  output logic [11:0]        tri_curr,
  output logic               table_full
);
  import mvd_pkg::*;

  cmd_t    cmd;
  status_t status;

  mvd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .status(status)
  );

  mvd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .face_start(face_start), .pos_index(pos_index), .uv_index(uv_index),
    .normal_index(normal_index), .strobe(valid), .vertex_number(vertex_number),
    .is_new(is_new), .tri_valid(tri_valid), .tri_first(tri_first),
    .tri_prev(tri_prev), .tri_curr(tri_curr), .table_full(table_full)
  );

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    valid |-> !(table_full && (is_new || tri_valid)))
    else $error("table_full result carries vertex data");
  a_busy_on_result: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("result without an item in flight");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after accepting an item");
endmodule

// File: sv/mvd_datapath.sv
// Datapath: key register, multi-cycle hash, table memories, valid clear sweep, fan state.
// Depends on mvd_pkg.
module mvd_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  mvd_pkg::cmd_t           cmd,
  output mvd_pkg::status_t        status,
  input  logic                    face_start,
  input  logic [19:0]             pos_index,
  input  logic signed [20:0]      uv_index,
  input  logic signed [20:0]      normal_index,
  output logic                    strobe,
  output logic [11:0]             vertex_number,
  output logic                    is_new,
  output logic                    tri_valid,
  output logic [11:0]             tri_first,
  output logic [11:0]             tri_prev,
  output logic [11:0]             tri_curr,
  output logic                    table_full
);
  import mvd_pkg::*;

  key_t                 key;
  logic                 fs;
  logic [63:0]          prod;
  logic [63:0]          keyx;
  slot_t                slot;
  logic [ProbeBits-1:0] probes;
  logic [CountBits-1:0] next_number;
  num_t                 face_first_number;
  num_t                 face_prev_number;
  logic [1:0]           corner_count;
  logic                 rd_valid;
  key_t                 rd_key;
  num_t                 rd_num;
  logic [SlotBits:0]    clr_addr;
  logic                 valid_mem [TableDepth];
  key_t                 key_mem [TableDepth];
  num_t                 num_mem [TableDepth];
  logic [63:0]          h;
  num_t                 num;

  assign keyx = {{(64-KeyBits){1'b0}}, key};
  assign h = prod ^ (prod >> 29);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= {normal_index[IndexBits:0], uv_index[IndexBits:0], pos_index[IndexBits-1:0]};
      fs  <= face_start;
    end
    if (cmd.hash_lo) begin
      prod <= 64'(keyx[31:0]) * 64'(HashMul[31:0]);
    end
    if (cmd.hash_hi) begin
      prod <= prod + {keyx[31:0] * HashMul[63:32] + keyx[63:32] * HashMul[31:0], 32'd0};
    end
    if (cmd.hash_fin) begin
      slot   <= h[SlotBits-1:0];
      probes <= '0;
    end
    if (cmd.advance) begin
      slot   <= slot + 1'b1;
      probes <= probes + 1'b1;
    end
    if (cmd.read) begin
      rd_key <= key_mem[slot];
      rd_num <= num_mem[slot];
    end
    if (cmd.insert) begin
      key_mem[slot] <= key;
      num_mem[slot] <= next_number[NumBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      valid_mem[clr_addr[SlotBits-1:0]] <= 1'b0;
    end else if (cmd.insert) begin
      valid_mem[slot] <= 1'b1;
    end
    if (cmd.read) begin
      rd_valid <= valid_mem[slot];
    end
  end

  assign status.hit        = rd_valid && (rd_key == key);
  assign status.empty      = !rd_valid;
  assign status.exhausted  = (probes == ProbeBits'(TableDepth));
  assign status.clear_done = clr_addr[SlotBits];
  assign status.no_number  = (next_number == CountBits'(TableDepth));

  assign num = cmd.insert ? next_number[NumBits-1:0] : rd_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr          <= '0;
      next_number       <= '0;
      face_first_number <= '0;
      face_prev_number  <= '0;
      corner_count      <= '0;
      strobe            <= 1'b0;
    end else begin
      strobe <= cmd.finish;
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.insert) begin
        next_number <= next_number + 1'b1;
      end
      if (cmd.finish) begin
        vertex_number <= '0;
        is_new        <= 1'b0;
        tri_valid     <= 1'b0;
        tri_first     <= '0;
        tri_prev      <= '0;
        tri_curr      <= '0;
        table_full    <= 1'b0;
        if (!status.hit && !cmd.insert) begin
          table_full <= 1'b1;
          if (fs) begin
            corner_count <= '0;
          end
        end else begin
          vertex_number    <= num;
          is_new           <= cmd.insert;
          face_prev_number <= num;
          if (fs || corner_count == 2'd0) begin
            face_first_number <= num;
            corner_count      <= 2'd1;
          end else begin
            if (corner_count == 2'd2) begin
              tri_valid <= 1'b1;
              tri_first <= face_first_number;
              tri_prev  <= face_prev_number;
              tri_curr  <= num;
            end
            corner_count <= 2'd2;
          end
        end
      end
    end
  end
endmodule

// File: sv/mvd_ctrl.sv
// Controller state machine sequencing hash, probe, insert and the clear sweep.
// Depends on mvd_pkg.
module mvd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output mvd_pkg::cmd_t     cmd,
  input  mvd_pkg::status_t  status
);
  import mvd_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_HASH1 = 8'b00000100,
    S_HASH2 = 8'b00001000,
    S_HASH3 = 8'b00010000,
    S_READ  = 8'b00100000,
    S_CHECK = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = !status.clear_done;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_HASH1;
        end
      end
      S_HASH1: begin
        cmd.hash_lo = 1'b1;
        state_next = S_HASH2;
      end
      S_HASH2: begin
        cmd.hash_hi = 1'b1;
        state_next = S_HASH3;
      end
      S_HASH3: begin
        cmd.hash_fin = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.hit) begin
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end else if (status.empty || status.exhausted) begin
          cmd.insert = !status.no_number && !status.exhausted;
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: bench/mesh_vertex_dedup_fan_indexer_top_tb.sv
// Testbench for the mesh vertex dedup and fan indexer: drives corners, predicts
// vertex numbers, new flags, fan triangles and table overflow, and checks each result.
// Depends on mvd_pkg and mesh_vertex_dedup_fan_indexer_top.
module mesh_vertex_dedup_fan_indexer_top_tb;
  import mvd_pkg::*;

  typedef struct packed {
    logic               fs;
    logic [19:0]        pos;
    logic signed [20:0] uv;
    logic signed [20:0] nrm;
  } corner_t;

  typedef struct packed {
    logic [11:0] vnum;
    logic        fresh;
    logic        tvalid;
    logic [11:0] tfirst;
    logic [11:0] tprev;
    logic [11:0] tcurr;
    logic        full;
  } vert_res_t;

  localparam int LimitCycles = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic face_start = 1'b0;
  logic [19:0] pos_index = '0;
  logic signed [20:0] uv_index = '0;
  logic signed [20:0] normal_index = '0;
  logic valid;
  logic [11:0] vertex_number, tri_first, tri_prev, tri_curr;
  logic is_new, tri_valid, table_full;

  mesh_vertex_dedup_fan_indexer_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .face_start(face_start), .pos_index(pos_index), .uv_index(uv_index),
    .normal_index(normal_index), .valid(valid), .vertex_number(vertex_number),
    .is_new(is_new), .tri_valid(tri_valid), .tri_first(tri_first),
    .tri_prev(tri_prev), .tri_curr(tri_curr), .table_full(table_full)
  );

  always #6 clk = ~clk;

  corner_t   pending_corners[$];
  vert_res_t expected_verts[$];
  int        vertex_of_key[key_t];
  int        assigned_count = 0;
  logic [11:0] fan_first = '0;
  logic [11:0] fan_prev = '0;
  int        fan_count = 0;
  int        errors = 0;
  int        cycles = 0;
  int        gap_left;
  bit        hold_for_drain = 1'b0;

  // Exact-match dedup: table exhaustion is purely a count of distinct triples.
  function automatic vert_res_t predict_corner(corner_t c);
    vert_res_t r;
    key_t k;
    int num;
    r = '0;
    k = {c.nrm, c.uv, c.pos};
    if (c.fs) fan_count = 0;
    if (vertex_of_key.exists(k)) begin
      num = vertex_of_key[k];
    end else if (assigned_count >= TableDepth) begin
      r.full = 1'b1;
      return r;
    end else begin
      num = assigned_count;
      vertex_of_key[k] = num;
      assigned_count++;
      r.fresh = 1'b1;
    end
    r.vnum = num[11:0];
    if (fan_count == 0) fan_first = num[11:0];
    if (fan_count >= 2) begin
      r.tvalid = 1'b1;
      r.tfirst = fan_first;
      r.tprev = fan_prev;
      r.tcurr = num[11:0];
    end
    fan_prev = num[11:0];
    if (fan_count < 2) fan_count++;
    return r;
  endfunction

  function automatic logic signed [20:0] rand_attr();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return -21'sd1;
    if (sel == 2) return 21'($urandom);
    if (sel < 6) return 21'($urandom_range(0, 15));
    return 21'($urandom_range(0, 1048575));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      start <= 1'b0;
      expected_verts.insert(expected_verts.size(), predict_corner(pending_corners.pop_front()));
      if (pending_corners.size() > 200 && $urandom_range(0, 3) == 0)
        gap_left <= $urandom_range(1, 8);
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_corners.size() > 0 &&
                   !(hold_for_drain && expected_verts.size() > 0)) begin
        start <= 1'b1;
        face_start <= pending_corners[0].fs;
        pos_index <= pending_corners[0].pos;
        uv_index <= pending_corners[0].uv;
        normal_index <= pending_corners[0].nrm;
      end
    end
  end

  always @(posedge clk) begin
    vert_res_t got, want;
    if (!rst && valid) begin
      got = {vertex_number, is_new, tri_valid, tri_first, tri_prev, tri_curr, table_full};
      if (expected_verts.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, got);
        errors++;
      end else begin
        want = expected_verts.pop_front();
        if (got.vnum !== want.vnum)
          $display("%0t vertex_number expected %0d actual %0d", $time, want.vnum, got.vnum);
        if (got.fresh !== want.fresh)
          $display("%0t is_new expected %0b actual %0b", $time, want.fresh, got.fresh);
        if (got.tvalid !== want.tvalid)
          $display("%0t tri_valid expected %0b actual %0b", $time, want.tvalid, got.tvalid);
        if (got.tfirst !== want.tfirst)
          $display("%0t tri_first expected %0d actual %0d", $time, want.tfirst, got.tfirst);
        if (got.tprev !== want.tprev)
          $display("%0t tri_prev expected %0d actual %0d", $time, want.tprev, got.tprev);
        if (got.tcurr !== want.tcurr)
          $display("%0t tri_curr expected %0d actual %0d", $time, want.tcurr, got.tcurr);
        if (got.full !== want.full)
          $display("%0t table_full expected %0b actual %0b", $time, want.full, got.full);
        if (got !== want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_corner(logic fs, logic [19:0] p, logic signed [20:0] u,
                              logic signed [20:0] n);
    corner_t c;
    c.fs = fs;
    c.pos = p;
    c.uv = u;
    c.nrm = n;
    pending_corners.insert(pending_corners.size(), c);
  endtask

  task automatic wait_drained();
    while (pending_corners.size() > 0 || start || expected_verts.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int corners_left;
    int face_len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Corners before any face start, extremes, repeats and negative non-absent codes.
    queue_corner(1'b0, 20'd0, -21'sd1, -21'sd1);
    queue_corner(1'b0, 20'hFFFFF, 21'sd1048575, 21'sd1048575);
    queue_corner(1'b0, 20'd0, -21'sd1, -21'sd1);
    queue_corner(1'b0, 20'd5, -21'sd2, -21'sd1048576);
    queue_corner(1'b1, 20'd1, 21'sd0, 21'sd0);
    queue_corner(1'b0, 20'd2, 21'sd0, -21'sd1);
    queue_corner(1'b0, 20'd3, -21'sd1, 21'sd0);
    queue_corner(1'b0, 20'd1, 21'sd0, 21'sd0);
    queue_corner(1'b1, 20'd2, 21'sd0, -21'sd1);
    queue_corner(1'b1, 20'd3, -21'sd1, 21'sd0);
    queue_corner(1'b0, 20'hAAAAA, 21'sh0AAAAA, 21'sh155555);
    queue_corner(1'b0, 20'h55555, 21'sh155555, 21'sh0AAAAA);
    queue_corner(1'b1, 20'd0, -21'sd1, -21'sd1);
    hold_for_drain = 1'b1;
    wait_drained();
    hold_for_drain = 1'b0;

    // Random faces, about half their positions drawn from a small pool so triples repeat often.
    corners_left = 1600;
    while (corners_left > 0) begin
      face_len = $urandom_range(3, 7);
      if ($urandom_range(0, 9) == 0) face_len = $urandom_range(1, 2);
      for (int i = 0; i < face_len; i++) begin
        if ($urandom_range(0, 1))
          queue_corner(i == 0, 20'($urandom_range(0, 63)), rand_attr(), rand_attr());
        else
          queue_corner((i == 0) ^ ($urandom_range(0, 19) == 0),
                       20'($urandom_range(0, 1048575)), rand_attr(), rand_attr());
      end
      corners_left -= face_len;
    end
    wait_drained();

    // Close with repeats and fresh triples across face starts.
    queue_corner(1'b1, 20'd0, -21'sd1, -21'sd1);
    queue_corner(1'b0, 20'd7, 21'sd7, 21'sd7);
    queue_corner(1'b0, 20'd1, 21'sd0, 21'sd0);
    queue_corner(1'b0, 20'd2, 21'sd0, -21'sd1);
    queue_corner(1'b1, 20'd9, 21'sd9, 21'sd9);
    queue_corner(1'b0, 20'd3, -21'sd1, 21'sd0);
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
sv/mvd_pkg.sv
sv/mvd_datapath.sv
sv/mvd_ctrl.sv
sv/mesh_vertex_dedup_fan_indexer_top.sv
bench/mesh_vertex_dedup_fan_indexer_top_tb.sv
